### design/tngs_pkg.sv
package tngs_pkg;

    // field widths of the words
    localparam int KIND_W     = 2;
    localparam int FUNC_W     = 4;
    localparam int NET_W      = 10;
    localparam int FANIN_W    = 3;
    localparam int PV_W       = 2;
    localparam int LUT_W      = 16;
    localparam int TAG_W      = 2;

    // sizing
    localparam int NETS_DEF   = 1024;
    localparam int MAX_FANIN  = 4;
    localparam int NET_FIELDS = 4;

    typedef logic [TAG_W-1:0]                  t_tag;
    typedef logic [NET_W-1:0]                  t_net;
    typedef logic [KIND_W-1:0]                 t_kind;
    typedef logic [FUNC_W-1:0]                 t_func;
    typedef logic [NET_FIELDS-1:0][TAG_W-1:0]  t_tag_set;

    // tags
    localparam t_tag TAG_UNK  = 2'd0;
    localparam t_tag TAG_ZERO = 2'd1;
    localparam t_tag TAG_ONE  = 2'd2;

    // item kinds
    localparam t_kind KIND_CLEAR = 2'd0;
    localparam t_kind KIND_SET   = 2'd1;
    localparam t_kind KIND_EVAL  = 2'd2;
    localparam t_kind KIND_READ  = 2'd3;

    // gate functions
    localparam t_func FN_AND    = 4'd0;
    localparam t_func FN_NAND   = 4'd1;
    localparam t_func FN_OR     = 4'd2;
    localparam t_func FN_NOR    = 4'd3;
    localparam t_func FN_XOR    = 4'd4;
    localparam t_func FN_XNOR   = 4'd5;
    localparam t_func FN_NOT    = 4'd6;
    localparam t_func FN_BUF    = 4'd7;
    localparam t_func FN_CONST0 = 4'd8;
    localparam t_func FN_CONST1 = 4'd9;
    localparam t_func FN_LUT    = 4'd10;

    // primary input drive codes
    localparam logic [PV_W-1:0] PV_ZERO = 2'd0;
    localparam logic [PV_W-1:0] PV_ONE  = 2'd1;

    typedef struct packed {
        t_kind               kind;
        t_func               gate_func;
        t_net                out_net;
        logic [FANIN_W-1:0]  fanin;
        t_net                in_net_a;
        t_net                in_net_b;
        t_net                in_net_c;
        t_net                in_net_d;
        logic [PV_W-1:0]     pi_value;
        logic [LUT_W-1:0]    lut_table;
    } t_in_word;

    typedef struct packed {
        t_tag  net_tag;
        t_net  net_index;
    } t_out_word;

    function automatic t_tag bool_tag(input logic b);
        return b ? TAG_ONE : TAG_ZERO;
    endfunction

endpackage

### design/tngs_tag_ram.sv
module tngs_tag_ram #(
    parameter int NETS = tngs_pkg::NETS_DEF,
    localparam int AW  = $clog2(NETS)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tngs_pkg::t_tag  i_wdata,
    input  logic [AW-1:0]   i_raddr0,
    input  logic [AW-1:0]   i_raddr1,
    output tngs_pkg::t_tag  o_rdata0,
    output tngs_pkg::t_tag  o_rdata1
);
    import tngs_pkg::*;

    t_tag r_mem [NETS];
    t_tag r_rdata0;
    t_tag r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read before write on a shared address
    always_ff @(posedge i_clk) begin
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

### design/tngs_gate_eval.sv
module tngs_gate_eval (
    input  tngs_pkg::t_func                     i_func,
    input  logic [tngs_pkg::FANIN_W-1:0]        i_fanin,
    input  tngs_pkg::t_tag_set                  i_tags,
    input  logic [tngs_pkg::LUT_W-1:0]          i_lut,
    output tngs_pkg::t_tag                      o_tag
);
    import tngs_pkg::*;

    localparam int FANIN_LIM = (MAX_FANIN < NET_FIELDS) ? MAX_FANIN : NET_FIELDS;

    logic [FANIN_W-1:0]     lim;
    logic                   any0;
    logic                   any1;
    logic                   allknown;
    logic                   par;
    logic [NET_FIELDS-1:0]  pat;
    t_tag                   tag;

    assign lim = (i_fanin > FANIN_W'(FANIN_LIM)) ? FANIN_W'(FANIN_LIM) : i_fanin;

    // summary over the inputs in use
    always_comb begin
        any0     = 1'b0;
        any1     = 1'b0;
        allknown = 1'b1;
        par      = 1'b0;
        pat      = '0;
        for (int i = 0; i < NET_FIELDS; i++) begin
            if (FANIN_W'(i) < lim) begin
                if (i_tags[i] == TAG_ZERO) begin
                    any0 = 1'b1;
                end else if (i_tags[i] == TAG_ONE) begin
                    any1   = 1'b1;
                    par    = ~par;
                    pat[i] = 1'b1;
                end else begin
                    allknown = 1'b0;
                end
            end
        end
    end

    always_comb begin
        unique case (i_func)
            FN_AND, FN_NAND: begin
                if (any0) begin
                    tag = bool_tag(i_func == FN_NAND);
                end else if (!allknown) begin
                    tag = TAG_UNK;
                end else begin
                    tag = bool_tag(i_func == FN_AND);
                end
            end
            FN_OR, FN_NOR: begin
                if (any1) begin
                    tag = bool_tag(i_func == FN_OR);
                end else if (!allknown) begin
                    tag = TAG_UNK;
                end else begin
                    tag = bool_tag(i_func == FN_NOR);
                end
            end
            FN_XOR, FN_XNOR: begin
                tag = allknown ? bool_tag(par ^ (i_func == FN_XNOR)) : TAG_UNK;
            end
            FN_NOT: begin
                if (i_tags[0] == TAG_ZERO) begin
                    tag = TAG_ONE;
                end else if (i_tags[0] == TAG_ONE) begin
                    tag = TAG_ZERO;
                end else begin
                    tag = TAG_UNK;
                end
            end
            FN_BUF:    tag = i_tags[0];
            FN_CONST0: tag = TAG_ZERO;
            FN_CONST1: tag = TAG_ONE;
            FN_LUT:    tag = allknown ? bool_tag(i_lut[pat]) : TAG_UNK;
            default:   tag = TAG_UNK;
        endcase
    end

    assign o_tag = tag;

endmodule

### design/ternary_netlist_gate_simulator.sv
// channel   | ports                     | handshake
// ----------+---------------------------+--------------------------------------------
// item in   | i_word (t_in_word)        | taken on a clock edge with start high, busy low
// result    | o_word (t_out_word)       | o_strobe high for one cycle, no back-pressure
//
// one item per cycle for set, evaluate and read while busy is low; an accepted item
// loads the input register and the tag ram read register, then the result register,
// which drives the strobe
// a clear holds busy high while the tag ram is swept to unknown,
// one net per cycle through its single write port
// after reset the same sweep runs, with busy high until it ends
// results are never held back: the receiver takes every strobed word
module ternary_netlist_gate_simulator #(
    parameter int NETS = tngs_pkg::NETS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tngs_pkg::t_in_word  i_word,
    output logic                o_strobe,
    output tngs_pkg::t_out_word o_word
);
    import tngs_pkg::*;

    localparam int AW = $clog2(NETS);

    // stage one: the accepted word, tags arrive from the ram register
    logic       r_s1_valid;
    t_in_word   r_s1;

    // last write, for the item that read the ram at the same edge
    logic       r_fw_valid;
    t_net       r_fw_net;
    t_tag       r_fw_tag;

    // clearing sweep
    logic           r_sweep;
    logic [AW-1:0]  r_sweep_cnt;

    // result register
    logic       r_out_valid;
    t_out_word  r_out;

    logic       accept;
    t_net       rd_net_a;
    t_tag       ram_a;
    t_tag       ram_b;
    t_tag       ram_c;
    t_tag       ram_d;
    t_tag_set   ram_tags;
    t_net [NET_FIELDS-1:0] s1_nets;
    t_tag_set   tags;
    t_tag       eval_tag;
    t_tag       n_tag;
    logic       out_in_range;
    logic       s1_wr;
    logic           we;
    logic [AW-1:0]  waddr;
    t_tag           wdata;

    assign busy   = r_sweep;
    assign accept = start & ~busy;

    // a read uses port a of the first copy
    assign rd_net_a = (i_word.kind == KIND_READ) ? i_word.out_net : i_word.in_net_a;

    // two copies of the tag store, each with two read ports, written together
    tngs_tag_ram #(.NETS(NETS)) u_ram_ab (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (AW'(rd_net_a)),
        .i_raddr1 (AW'(i_word.in_net_b)),
        .o_rdata0 (ram_a),
        .o_rdata1 (ram_b)
    );

    tngs_tag_ram #(.NETS(NETS)) u_ram_cd (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (AW'(i_word.in_net_c)),
        .i_raddr1 (AW'(i_word.in_net_d)),
        .o_rdata0 (ram_c),
        .o_rdata1 (ram_d)
    );

    assign ram_tags = {ram_d, ram_c, ram_b, ram_a};
    assign s1_nets  = {r_s1.in_net_d, r_s1.in_net_c, r_s1.in_net_b,
                       (r_s1.kind == KIND_READ) ? r_s1.out_net : r_s1.in_net_a};

    // forward the write that landed as this item read; nets past the end read unknown
    always_comb begin
        for (int i = 0; i < NET_FIELDS; i++) begin
            if (32'(s1_nets[i]) >= 32'(NETS)) begin
                tags[i] = TAG_UNK;
            end else if (r_fw_valid && (r_fw_net == s1_nets[i])) begin
                tags[i] = r_fw_tag;
            end else begin
                tags[i] = ram_tags[i];
            end
        end
    end

    tngs_gate_eval u_eval (
        .i_func  (r_s1.gate_func),
        .i_fanin (r_s1.fanin),
        .i_tags  (tags),
        .i_lut   (r_s1.lut_table),
        .o_tag   (eval_tag)
    );

    always_comb begin
        unique case (r_s1.kind)
            KIND_CLEAR: n_tag = TAG_UNK;
            KIND_SET: begin
                if (r_s1.pi_value == PV_ZERO) begin
                    n_tag = TAG_ZERO;
                end else if (r_s1.pi_value == PV_ONE) begin
                    n_tag = TAG_ONE;
                end else begin
                    n_tag = TAG_UNK;
                end
            end
            KIND_EVAL:  n_tag = eval_tag;
            KIND_READ:  n_tag = tags[0];
            default:    n_tag = TAG_UNK;
        endcase
    end

    // writes past the last net are dropped
    assign out_in_range = 32'(r_s1.out_net) < 32'(NETS);
    assign s1_wr = r_s1_valid && out_in_range &&
                   ((r_s1.kind == KIND_SET) || (r_s1.kind == KIND_EVAL));

    // the sweep and an item write never share a cycle
    assign we    = r_sweep | s1_wr;
    assign waddr = r_sweep ? r_sweep_cnt : AW'(r_s1.out_net);
    assign wdata = r_sweep ? TAG_UNK : n_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_sweep     <= 1'b1;
            r_sweep_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= accept;
            r_fw_valid  <= s1_wr;
            r_out_valid <= r_s1_valid;
            if (r_sweep) begin
                if (r_sweep_cnt == AW'(NETS - 1)) begin
                    r_sweep <= 1'b0;
                end
                r_sweep_cnt <= r_sweep_cnt + 1'b1;
            end else if (accept && (i_word.kind == KIND_CLEAR)) begin
                r_sweep     <= 1'b1;
                r_sweep_cnt <= '0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_word;
        end
        r_fw_net        <= r_s1.out_net;
        r_fw_tag        <= n_tag;
        r_out.net_tag   <= n_tag;
        r_out.net_index <= r_s1.out_net;
    end

    assign o_strobe = r_out_valid;
    assign o_word   = r_out;

endmodule

### bench/ternary_netlist_gate_simulator_test.sv
module ternary_netlist_gate_simulator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tngs_pkg::*;

    // clocking and run control
    localparam int CLK_HALF_NS  = 2;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int REPORT_LIMIT = 10;
    localparam int TAIL_CYCLES  = 8;
    localparam int POOL_DEPTH   = 24;

    // codes outside the named ranges of the package, and edge values inside them
    localparam t_func                FN_SPARE   = 4'd15;  // undefined gate, gives unknown
    localparam logic [PV_W-1:0]      PV_UNK_LO  = 2'd2;   // both of these drive unknown
    localparam logic [PV_W-1:0]      PV_UNK_HI  = 2'd3;
    localparam logic [FANIN_W-1:0]   FANIN_OVER = 3'd7;   // clipped to the four net fields
    localparam logic [FANIN_W-1:0]   FANIN_FULL = 3'd4;
    localparam t_net                 NET_TOP    = t_net'(NETS_DEF - 1);

    // tracks the tag table and the words that must come back, in order
    class net_tag_scoreboard;
        t_tag      net_tags[NETS_DEF];
        t_out_word expected_words[$];
        int        mismatches;

        function new();
            foreach (net_tags[i]) net_tags[i] = TAG_UNK;
            mismatches = 0;
        endfunction

        function t_tag logic_tag(bit b);
            return b ? TAG_ONE : TAG_ZERO;
        endfunction

        // three-valued gate evaluation, inputs read before the output is written
        function t_tag gate_tag(t_in_word w);
            t_tag       ins[NET_FIELDS];
            int         n;
            bit         any0;
            bit         any1;
            bit         all_known;
            bit         parity;
            logic [3:0] pattern;
            t_tag       res;
            ins[0]    = net_tags[w.in_net_a];
            ins[1]    = net_tags[w.in_net_b];
            ins[2]    = net_tags[w.in_net_c];
            ins[3]    = net_tags[w.in_net_d];
            n         = int'(w.fanin);
            if (n > MAX_FANIN) n = MAX_FANIN;
            if (n > NET_FIELDS) n = NET_FIELDS;
            any0      = 1'b0;
            any1      = 1'b0;
            all_known = 1'b1;
            parity    = 1'b0;
            pattern   = '0;
            for (int i = 0; i < n; i++) begin
                if (ins[i] == TAG_ZERO) begin
                    any0 = 1'b1;
                end else if (ins[i] == TAG_ONE) begin
                    any1       = 1'b1;
                    parity     = ~parity;
                    pattern[i] = 1'b1;
                end else begin
                    all_known = 1'b0;
                end
            end
            case (w.gate_func)
                FN_AND, FN_NAND: begin
                    if (any0) res = logic_tag(w.gate_func == FN_NAND);
                    else if (!all_known) res = TAG_UNK;
                    else res = logic_tag(w.gate_func == FN_AND);
                end
                FN_OR, FN_NOR: begin
                    if (any1) res = logic_tag(w.gate_func == FN_OR);
                    else if (!all_known) res = TAG_UNK;
                    else res = logic_tag(w.gate_func == FN_NOR);
                end
                FN_XOR, FN_XNOR: begin
                    if (!all_known) res = TAG_UNK;
                    else res = logic_tag(parity ^ (w.gate_func == FN_XNOR));
                end
                FN_NOT: begin
                    if (ins[0] == TAG_ZERO) res = TAG_ONE;
                    else if (ins[0] == TAG_ONE) res = TAG_ZERO;
                    else res = TAG_UNK;
                end
                FN_BUF:    res = ins[0];
                FN_CONST0: res = TAG_ZERO;
                FN_CONST1: res = TAG_ONE;
                FN_LUT: begin
                    if (!all_known) res = TAG_UNK;
                    else res = logic_tag(w.lut_table[pattern]);
                end
                default:   res = TAG_UNK;
            endcase
            return res;
        endfunction

        function void note_word(t_in_word w);
            t_out_word e;
            e.net_index = w.out_net;
            case (w.kind)
                KIND_CLEAR: begin
                    foreach (net_tags[i]) net_tags[i] = TAG_UNK;
                    e.net_tag = TAG_UNK;
                end
                KIND_SET: begin
                    if (w.pi_value == PV_ZERO) e.net_tag = TAG_ZERO;
                    else if (w.pi_value == PV_ONE) e.net_tag = TAG_ONE;
                    else e.net_tag = TAG_UNK;
                    net_tags[w.out_net] = e.net_tag;
                end
                KIND_EVAL: begin
                    e.net_tag = gate_tag(w);
                    net_tags[w.out_net] = e.net_tag;
                end
                default: e.net_tag = net_tags[w.out_net];
            endcase
            expected_words.push_back(e);
        endfunction

        function void check_word(t_out_word got);
            t_out_word e;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word: net %0d tag %0d",
                             got.net_index, got.net_tag);
                return;
            end
            e = expected_words.pop_front();
            if (got.net_tag !== e.net_tag || got.net_index !== e.net_index) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected net %0d tag %0d, got net %0d tag %0d",
                             e.net_index, e.net_tag, got.net_index, got.net_tag);
            end
        endfunction
    endclass

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic       busy;
    t_in_word   i_word  = '0;
    logic       o_strobe;
    t_out_word  o_word;

    net_tag_scoreboard sb;
    int unsigned       cycle_count = 0;

    // nets recently written, so that gates mostly see known tags
    t_net net_pool[$];

    ternary_netlist_gate_simulator i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_word   (i_word),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

    always #CLK_HALF_NS i_clk = ~i_clk;

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // monitor: values sampled at the edge are the ones the block sees
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_word(i_word);
            if (o_strobe) sb.check_word(o_word);
        end
    end

    function automatic t_in_word make_word(t_kind k, t_func f, t_net o_net,
                                           logic [FANIN_W-1:0] n,
                                           t_net a, t_net b, t_net c, t_net d,
                                           logic [PV_W-1:0] pv, logic [LUT_W-1:0] lut);
        t_in_word w;
        w.kind      = k;
        w.gate_func = f;
        w.out_net   = o_net;
        w.fanin     = n;
        w.in_net_a  = a;
        w.in_net_b  = b;
        w.in_net_c  = c;
        w.in_net_d  = d;
        w.pi_value  = pv;
        w.lut_table = lut;
        return w;
    endfunction

    // mostly a net already driven in this stretch, now and then any net at all
    function automatic t_net pick_net();
        if (net_pool.size() == 0 || $urandom_range(9) == 0)
            return t_net'($urandom_range(NETS_DEF - 1));
        return net_pool[$urandom_range(net_pool.size() - 1)];
    endfunction

    function automatic void remember_net(t_net n);
        net_pool.push_back(n);
        if (net_pool.size() > POOL_DEPTH) void'(net_pool.pop_front());
    endfunction

    // one random word: mostly well-formed netlist traffic with random content
    function automatic t_in_word random_word();
        logic [95:0] bits;
        t_in_word    w;
        int          roll;
        bits = {$urandom(), $urandom(), $urandom()};
        w    = bits[$bits(t_in_word)-1:0];
        roll = $urandom_range(99);
        if (roll < 2) begin
            // occasional clear, long sweep inside the block
            w.kind = KIND_CLEAR;
            net_pool.delete();
        end else if (roll < 24) begin
            w.kind    = KIND_SET;
            w.out_net = ($urandom_range(3) == 0) ? pick_net()
                                                 : t_net'($urandom_range(NETS_DEF - 1));
            // favour known drives so gates have something to decide
            if ($urandom_range(3) != 0) w.pi_value = $urandom_range(1) ? PV_ONE : PV_ZERO;
            remember_net(w.out_net);
        end else if (roll < 82) begin
            w.kind = KIND_EVAL;
            if ($urandom_range(9) != 0) w.gate_func = t_func'($urandom_range(FN_LUT));
            if ($urandom_range(7) != 0)
                w.fanin = FANIN_W'($urandom_range(1, MAX_FANIN));
            w.in_net_a = pick_net();
            w.in_net_b = pick_net();
            w.in_net_c = pick_net();
            w.in_net_d = pick_net();
            // sometimes feed the gate its own output net
            if ($urandom_range(15) == 0) w.out_net = w.in_net_a;
            else if ($urandom_range(4) != 0) w.out_net = t_net'($urandom_range(NETS_DEF - 1));
            remember_net(w.out_net);
        end else if (roll < 94) begin
            w.kind    = KIND_READ;
            w.out_net = pick_net();
        end
        // remainder: raw noise with every field random
        return w;
    endfunction

    // present one word and hold it until the block takes it
    task automatic send_word(input t_in_word w, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        t_in_word directed_words[$];
        int       idle_plan[5];
        int       count_plan[5];

        idle_plan  = '{0, 88, 28, 0, 88};
        count_plan = '{500, 300, 500, 400, 300};
        sb = new();

        // synchronous reset, then the block sweeps its table while busy
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: drive levels, every gate, controlling values, edge nets
        directed_words = '{
            make_word(KIND_SET,  FN_AND,    '0,      '0, '0, '0, '0, '0, PV_ZERO,   '0),
            make_word(KIND_SET,  FN_AND,    NET_TOP, '0, '0, '0, '0, '0, PV_ONE,    '0),
            make_word(KIND_SET,  FN_AND,    10'd5,   '0, '0, '0, '0, '0, PV_UNK_LO, '0),
            make_word(KIND_SET,  FN_AND,    10'd6,   '0, '0, '0, '0, '0, PV_UNK_HI, '0),
            make_word(KIND_SET,  FN_AND,    10'd7,   '0, '0, '0, '0, '0, PV_ONE,    '0),
            // zero on one input decides the and
            make_word(KIND_EVAL, FN_AND,    10'd20, 3'd2, 10'd5, '0, '0, '0, PV_ZERO, '0),
            make_word(KIND_EVAL, FN_AND,    10'd21, 3'd2, NET_TOP, 10'd7, '0, '0, PV_ZERO, '0),
            make_word(KIND_EVAL, FN_NAND,   10'd22, 3'd2, NET_TOP, 10'd5, '0, '0, PV_ZERO, '0),
            make_word(KIND_EVAL, FN_NAND,   10'd23, 3'd2, 10'd6, '0, '0, '0, PV_ZERO, '0),
            // one on one input decides the or
            make_word(KIND_EVAL, FN_OR,     10'd24, 3'd3, 10'd5, 10'd6, NET_TOP, '0, PV_ZERO, '0),
            // no inputs in use
            make_word(KIND_EVAL, FN_NOR,    10'd25, 3'd0, 10'd5, 10'd6, '0, '0, PV_ZERO, '0),
            make_word(KIND_EVAL, FN_XOR,    10'd26, 3'd3, NET_TOP, 10'd7, '0, '0, PV_ZERO, '0),
            // fanin beyond the net fields
            make_word(KIND_EVAL, FN_XNOR,   10'd27, FANIN_OVER, NET_TOP, 10'd7, '0, 10'd21,
                      PV_ZERO, '0),
            // not and buf look only at the first input
            make_word(KIND_EVAL, FN_NOT,    10'd28, 3'd0, '0, 10'd5, 10'd5, 10'd5, PV_ZERO, '0),
            make_word(KIND_EVAL, FN_BUF,    10'd29, 3'd3, 10'd5, NET_TOP, '0, '0, PV_ZERO, '0),
            make_word(KIND_EVAL, FN_CONST0, 10'd30, FANIN_FULL, 10'd5, 10'd6, 10'd5, 10'd6,
                      PV_ZERO, '0),
            make_word(KIND_EVAL, FN_CONST1, 10'd31, 3'd1, 10'd5, '0, '0, '0, PV_ZERO, '0),
            make_word(KIND_EVAL, FN_LUT,    10'd32, FANIN_FULL, NET_TOP, '0, 10'd7, 10'd21,
                      PV_ZERO, 16'hA5C3),
            // lut with no inputs gives table bit zero
            make_word(KIND_EVAL, FN_LUT,    10'd33, 3'd0, 10'd5, '0, '0, '0, PV_ZERO, 16'hFFFF),
            make_word(KIND_EVAL, FN_SPARE,  10'd34, 3'd2, '0, NET_TOP, '0, '0, PV_ZERO, '1),
            // gate reading its own output net
            make_word(KIND_EVAL, FN_NOT,    10'd7,  3'd1, 10'd7, '0, '0, '0, PV_ZERO, '0),
            make_word(KIND_READ, FN_AND,    10'd7,   '0, '0, '0, '0, '0, PV_ZERO, '0),
            make_word(KIND_READ, FN_AND,    NET_TOP, '0, '0, '0, '0, '0, PV_ZERO, '0),
            make_word(KIND_CLEAR, FN_AND,   NET_TOP, '0, '0, '0, '0, '0, PV_ZERO, '0),
            make_word(KIND_READ, FN_AND,    '0,      '0, '0, '0, '0, '0, PV_ZERO, '0)
        };
        foreach (directed_words[i]) send_word(directed_words[i], 0);

        // random phases: back to back, sparse sender, moderate gaps
        foreach (idle_plan[p]) begin
            repeat (count_plan[p]) send_word(random_word(), idle_plan[p]);
        end
        start <= 1'b0;

        // drain, then give stray words time to show up
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.expected_words.size() != 0)
            $display("results still outstanding: %0d", sb.expected_words.size());
        if (sb.mismatches == 0 && sb.expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
design/tngs_pkg.sv
design/tngs_tag_ram.sv
design/tngs_gate_eval.sv
design/ternary_netlist_gate_simulator.sv
bench/ternary_netlist_gate_simulator_test.sv
